[hw/rtl/assert_macros.svh]
// Assertion macros shared by the classifier RTL.
// Bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every rising clock edge outside reset.
`define IPPC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Antecedent implies consequent at the next clock.
`define IPPC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);
`else
`define IPPC_ASSERT(lbl, clk, rstn, prop, msg)
`define IPPC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

[hw/rtl/ippc_pkg.sv]
// Types, codes and fixed address ranges of the IPv4 prefix policy classifier.
// No dependencies.
package ippc_pkg;

  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned PLEN_W   = 6;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned DEC_W    = 3;
  localparam int unsigned CNT_W    = 32;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 72;

  localparam logic [PLEN_W-1:0] PLEN_MAX = 6'd32;

  localparam logic [MODE_W-1:0] MODE_CHECK     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ADD_ALLOW = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ADD_DENY  = 2'd2;

  typedef enum logic [DEC_W-1:0] {
    DEC_ALLOW    = 3'd0,
    DEC_INTERNAL = 3'd1,
    DEC_METADATA = 3'd2,
    DEC_LOOPBACK = 3'd3,
    DEC_RESERVED = 3'd4,
    DEC_DENYLIST = 3'd5
  } dec_e;

  // One decided item handed from the front to the back.
  typedef struct packed {
    logic is_check;
    dec_e decision;
    logic stored;
  } q_entry_t;

  typedef struct packed {
    logic [ADDR_W-1:0] net;
    logic [PLEN_W-1:0] plen;
    dec_e              kind;
  } fixed_range_t;

  localparam int unsigned FIXED_N = 14;

  localparam fixed_range_t FIXED_RANGES [FIXED_N] = '{
    '{32'h0A000000, 6'd8,  DEC_INTERNAL},
    '{32'hAC100000, 6'd12, DEC_INTERNAL},
    '{32'hC0A80000, 6'd16, DEC_INTERNAL},
    '{32'h7F000000, 6'd8,  DEC_LOOPBACK},
    '{32'hA9FE0000, 6'd16, DEC_METADATA},
    '{32'h00000000, 6'd8,  DEC_RESERVED},
    '{32'h64400000, 6'd10, DEC_RESERVED},
    '{32'hC0000000, 6'd24, DEC_RESERVED},
    '{32'hC0000200, 6'd24, DEC_RESERVED},
    '{32'hC6336400, 6'd24, DEC_RESERVED},
    '{32'hCB007100, 6'd24, DEC_RESERVED},
    '{32'hE0000000, 6'd4,  DEC_RESERVED},
    '{32'hF0000000, 6'd4,  DEC_RESERVED},
    '{32'hFFFFFFFF, 6'd32, DEC_RESERVED}
  };

  // Top plen bits set; plen is at most 32.
  function automatic logic [ADDR_W-1:0] mask_of(input logic [PLEN_W-1:0] plen);
    mask_of = ~({ADDR_W{1'b1}} >> plen);
  endfunction

  function automatic logic prefix_hit(input logic [ADDR_W-1:0] addr,
                                      input logic [ADDR_W-1:0] net,
                                      input logic [PLEN_W-1:0] plen);
    logic [ADDR_W-1:0] m;
    m = mask_of(plen);
    prefix_hit = (addr & m) == (net & m);
  endfunction

  // First matching fixed range, or allow.
  function automatic dec_e fixed_class(input logic [ADDR_W-1:0] addr);
    dec_e k;
    k = DEC_ALLOW;
    for (int i = FIXED_N - 1; i >= 0; i--) begin
      if (prefix_hit(addr, FIXED_RANGES[i].net, FIXED_RANGES[i].plen)) begin
        k = FIXED_RANGES[i].kind;
      end
    end
    fixed_class = k;
  endfunction

endpackage

[hw/rtl/ippc_rule_table.sv]
// Append-only prefix rule table with parallel lookup over the filled entries.
// Depends on ippc_pkg.
`include "assert_macros.svh"
module ippc_rule_table
  import ippc_pkg::*;
#(
  parameter int unsigned ENTRIES = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_net_i,
  input  logic [PLEN_W-1:0] wr_plen_i,
  input  logic [ADDR_W-1:0] addr_i,
  output logic              hit_o,
  output logic              full_o
);

  localparam int unsigned FW = $clog2(ENTRIES + 1);

  logic [ADDR_W-1:0] net_q  [ENTRIES];
  logic [PLEN_W-1:0] plen_q [ENTRIES];
  logic [FW-1:0]     fill_q, fill_d;
  logic [PLEN_W-1:0] plen_sat;
  logic [ENTRIES-1:0] hit_vec;
  logic              do_wr;

  assign full_o   = (fill_q == FW'(ENTRIES));
  assign do_wr    = wr_en_i && !full_o;
  assign plen_sat = (wr_plen_i > PLEN_MAX) ? PLEN_MAX : wr_plen_i;
  assign fill_d   = do_wr ? fill_q + FW'(1) : fill_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  // Entries above the fill count are never looked at, so no reset.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (do_wr && fill_q == FW'(i)) begin
        net_q[i]  <= wr_net_i;
        plen_q[i] <= plen_sat;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i] = (FW'(i) < fill_q) && prefix_hit(addr_i, net_q[i], plen_q[i]);
    end
  end

  assign hit_o = |hit_vec;

  `IPPC_ASSERT(a_fill_bound, clk_i, rst_ni, fill_q <= FW'(ENTRIES), "rule fill overran table")

endmodule

[hw/rtl/ippc_front.sv]
// Front end: accepts items, holds the enable register, updates the rule
// tables and decides each item. Depends on ippc_pkg and ippc_rule_table.
module ippc_front
  import ippc_pkg::*;
#(
  parameter int unsigned ALLOW_ENTRIES = 8,
  parameter int unsigned DENY_ENTRIES  = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [MODE_W-1:0] mode_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [PLEN_W-1:0] plen_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output q_entry_t          q_entry_o
);

  logic filter_en_q, filter_en_d;
  logic accept, wr_allow, wr_deny;
  logic allow_hit, allow_full, deny_hit, deny_full;

  assign cfg_ready_o = 1'b1;
  assign filter_en_d = cfg_valid_i ? cfg_data_i : filter_en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_en_q <= 1'b1;
    end else begin
      filter_en_q <= filter_en_d;
    end
  end

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign q_push_o   = accept;
  assign wr_allow   = accept && (mode_i == MODE_ADD_ALLOW);
  assign wr_deny    = accept && (mode_i == MODE_ADD_DENY);

  ippc_rule_table #(.ENTRIES(ALLOW_ENTRIES)) u_allow (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_allow),
    .wr_net_i  (addr_i),
    .wr_plen_i (plen_i),
    .addr_i    (addr_i),
    .hit_o     (allow_hit),
    .full_o    (allow_full)
  );

  ippc_rule_table #(.ENTRIES(DENY_ENTRIES)) u_deny (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_deny),
    .wr_net_i  (addr_i),
    .wr_plen_i (plen_i),
    .addr_i    (addr_i),
    .hit_o     (deny_hit),
    .full_o    (deny_full)
  );

  always_comb begin
    q_entry_o.is_check = 1'b0;
    q_entry_o.decision = DEC_ALLOW;
    q_entry_o.stored   = 1'b1;
    case (mode_i)
      MODE_ADD_ALLOW: q_entry_o.stored = !allow_full;
      MODE_ADD_DENY:  q_entry_o.stored = !deny_full;
      default: begin
        // check; the unused mode code is a check too
        q_entry_o.is_check = 1'b1;
        if (!filter_en_q || allow_hit) begin
          q_entry_o.decision = DEC_ALLOW;
        end else if (deny_hit) begin
          q_entry_o.decision = DEC_DENYLIST;
        end else begin
          q_entry_o.decision = fixed_class(addr_i);
        end
      end
    endcase
  end

endmodule

[hw/rtl/ippc_queue.sv]
// Short FIFO of decided items between front and back.
// Depends on ippc_pkg.
`include "assert_macros.svh"
module ippc_queue
  import ippc_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  q_entry_t push_data_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     valid_o,
  output q_entry_t pop_data_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  q_entry_t      mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          do_push, do_pop;

  assign full_o     = (count_q == CW'(DEPTH));
  assign valid_o    = (count_q != '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `IPPC_ASSERT(a_no_push_full, clk_i, rst_ni, !(push_i && full_o), "push into full queue")
  `IPPC_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CW'(DEPTH), "queue count overran")

endmodule

[hw/rtl/ippc_back.sv]
// Back end: updates the allow and block counters and holds the result beat.
// Depends on ippc_pkg.
`include "assert_macros.svh"
module ippc_back
  import ippc_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   q_valid_i,
  input  q_entry_t               q_entry_i,
  output logic                   q_pop_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [OUT_TDATA_W-1:0] out_data_o
);

  logic [CNT_W-1:0] allow_cnt_q, allow_cnt_d, block_cnt_q, block_cnt_d;
  logic             valid_q, valid_d;
  dec_e             dec_q;
  logic             stored_q;

  assign q_pop_o = q_valid_i && (!valid_q || out_ready_i);

  always_comb begin
    allow_cnt_d = allow_cnt_q;
    block_cnt_d = block_cnt_q;
    if (q_pop_o && q_entry_i.is_check) begin
      if (q_entry_i.decision == DEC_ALLOW) begin
        allow_cnt_d = allow_cnt_q + CNT_W'(1);
      end else begin
        block_cnt_d = block_cnt_q + CNT_W'(1);
      end
    end
    valid_d = q_pop_o ? 1'b1 : (valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      allow_cnt_q <= '0;
      block_cnt_q <= '0;
      valid_q     <= 1'b0;
    end else begin
      allow_cnt_q <= allow_cnt_d;
      block_cnt_q <= block_cnt_d;
      valid_q     <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      dec_q    <= q_entry_i.decision;
      stored_q <= q_entry_i.stored;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = {4'b0, block_cnt_q, allow_cnt_q, stored_q, dec_q};

  `IPPC_ASSERT_NEXT(a_insert_keeps_cnt, clk_i, rst_ni, q_pop_o && !q_entry_i.is_check,
    $stable(allow_cnt_q) && $stable(block_cnt_q), "insert changed a counter")

endmodule

[hw/rtl/ipv4_prefix_policy_classifier.sv]
// Top level of the IPv4 prefix policy classifier.
// Depends on ippc_pkg, ippc_front, ippc_queue and ippc_back.
//
//  channel  | dir | handshake                    | payload
//  ---------+-----+------------------------------+--------------------------------
//  s_axis   | in  | s_axis_tvalid / s_axis_tready | tdata address, prefix_len; tuser mode
//  m_axis   | out | m_axis_tvalid / m_axis_tready | tdata decision, stored, totals
//  cfg      | in  | cfg_valid_i / cfg_ready_o     | filter_enabled
//
// One item per cycle sustained while m_axis is ready; a result passes a queue
// slot, then the output register. All rule entries are compared in
// parallel in the front, counters are updated in the back.
// A stalled m_axis fills the two-entry queue, then drops s_axis_tready.
// Reset clears fill counts, totals and queue; filter_enabled resets to 1.
module ipv4_prefix_policy_classifier
  import ippc_pkg::*;
#(
  parameter int unsigned ALLOW_ENTRIES = 8,
  parameter int unsigned DENY_ENTRIES  = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic                   cfg_data_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [31:0] address, [37:32] prefix_len, [39:38] zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // [1:0] mode
  input  logic [MODE_W-1:0]      s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [2:0] decision, [3] rule_stored, [35:4] allowed_total,
  // [67:36] blocked_total, [71:68] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int unsigned QUEUE_DEPTH = 2;

  logic     q_push, q_full, q_pop, q_valid;
  q_entry_t q_in, q_out;

  ippc_front #(
    .ALLOW_ENTRIES (ALLOW_ENTRIES),
    .DENY_ENTRIES  (DENY_ENTRIES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .mode_i      (s_axis_tuser),
    .addr_i      (s_axis_tdata[ADDR_W-1:0]),
    .plen_i      (s_axis_tdata[ADDR_W+PLEN_W-1:ADDR_W]),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_entry_o   (q_in)
  );

  ippc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_in),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_out)
  );

  ippc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_entry_i   (q_out),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

[sim/ippc_decision_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the IPv4 prefix policy classifier: watches the cfg, s_axis and m_axis
// channels, predicts each result beat and compares it field by field. Depends on ippc_pkg.
module ippc_decision_checker
  import ippc_pkg::*;
#(
  parameter int unsigned ALLOW_ENTRIES = 8,
  parameter int unsigned DENY_ENTRIES  = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_i,
  input  logic                   cfg_data_i,
  input  logic                   s_tvalid_i,
  input  logic                   s_tready_i,
  input  logic [IN_TDATA_W-1:0]  s_tdata_i,
  input  logic [MODE_W-1:0]      s_tuser_i,
  input  logic                   m_tvalid_i,
  input  logic                   m_tready_i,
  input  logic [OUT_TDATA_W-1:0] m_tdata_i,
  output int                     mismatches_o,
  output int                     pending_o,
  output int                     compared_o,
  output int                     refused_o
);

  typedef struct packed {
    dec_e             decision;
    logic             stored;
    logic [CNT_W-1:0] allowed;
    logic [CNT_W-1:0] blocked;
  } verdict_t;

  typedef struct packed {
    logic [ADDR_W-1:0] net;
    logic [PLEN_W-1:0] len;
    dec_e              kind;
  } span_t;

  localparam int unsigned SPAN_N = 14;

  // First hit wins.
  localparam span_t SPECIAL_SPANS [SPAN_N] = '{
    '{32'h0A000000, 6'd8,  DEC_INTERNAL},
    '{32'hAC100000, 6'd12, DEC_INTERNAL},
    '{32'hC0A80000, 6'd16, DEC_INTERNAL},
    '{32'h7F000000, 6'd8,  DEC_LOOPBACK},
    '{32'hA9FE0000, 6'd16, DEC_METADATA},
    '{32'h00000000, 6'd8,  DEC_RESERVED},
    '{32'h64400000, 6'd10, DEC_RESERVED},
    '{32'hC0000000, 6'd24, DEC_RESERVED},
    '{32'hC0000200, 6'd24, DEC_RESERVED},
    '{32'hC6336400, 6'd24, DEC_RESERVED},
    '{32'hCB007100, 6'd24, DEC_RESERVED},
    '{32'hE0000000, 6'd4,  DEC_RESERVED},
    '{32'hF0000000, 6'd4,  DEC_RESERVED},
    '{32'hFFFFFFFF, 6'd32, DEC_RESERVED}
  };

  verdict_t          expected_verdicts [$];
  logic              filter_on;
  logic [ADDR_W-1:0] allow_net [ALLOW_ENTRIES];
  logic [PLEN_W-1:0] allow_len [ALLOW_ENTRIES];
  logic [ADDR_W-1:0] deny_net [DENY_ENTRIES];
  logic [PLEN_W-1:0] deny_len [DENY_ENTRIES];
  int                allow_used;
  int                deny_used;
  logic [CNT_W-1:0]  allowed_cnt;
  logic [CNT_W-1:0]  blocked_cnt;

  function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PLEN_W-1:0] len);
    logic [ADDR_W-1:0] m;
    for (int b = 0; b < ADDR_W; b++) m[ADDR_W-1-b] = (b < len);
    return m;
  endfunction

  function automatic logic covers(input logic [ADDR_W-1:0] addr,
                                  input logic [ADDR_W-1:0] net,
                                  input logic [PLEN_W-1:0] len);
    return ((addr ^ net) & prefix_mask(len)) == '0;
  endfunction

  function automatic dec_e classify_address(input logic [ADDR_W-1:0] addr);
    if (!filter_on) return DEC_ALLOW;
    for (int i = 0; i < allow_used; i++) begin
      if (covers(addr, allow_net[i], allow_len[i])) return DEC_ALLOW;
    end
    for (int i = 0; i < deny_used; i++) begin
      if (covers(addr, deny_net[i], deny_len[i])) return DEC_DENYLIST;
    end
    for (int i = 0; i < SPAN_N; i++) begin
      if (covers(addr, SPECIAL_SPANS[i].net, SPECIAL_SPANS[i].len)) begin
        return SPECIAL_SPANS[i].kind;
      end
    end
    return DEC_ALLOW;
  endfunction

  task automatic report_mismatch(input string what, input logic [CNT_W-1:0] got,
                                 input logic [CNT_W-1:0] want);
    mismatches_o++;
    $display("[%0t] result %0d: %s got 0x%0h, expected 0x%0h",
             $time, compared_o, what, got, want);
  endtask

  task automatic predict_beat();
    logic [ADDR_W-1:0] addr;
    logic [PLEN_W-1:0] len;
    verdict_t          v;
    addr = s_tdata_i[ADDR_W-1:0];
    len  = s_tdata_i[ADDR_W +: PLEN_W];
    len  = (len > PLEN_MAX) ? PLEN_MAX : len;
    v.decision = DEC_ALLOW;
    v.stored   = 1'b1;
    case (s_tuser_i)
      MODE_ADD_ALLOW: begin
        if (allow_used < ALLOW_ENTRIES) begin
          allow_net[allow_used] = addr;
          allow_len[allow_used] = len;
          allow_used++;
        end else begin
          v.stored = 1'b0;
          refused_o++;
        end
      end
      MODE_ADD_DENY: begin
        if (deny_used < DENY_ENTRIES) begin
          deny_net[deny_used] = addr;
          deny_len[deny_used] = len;
          deny_used++;
        end else begin
          v.stored = 1'b0;
          refused_o++;
        end
      end
      default: begin
        // the spare mode code decodes as a check too
        v.decision = classify_address(addr);
        if (v.decision == DEC_ALLOW) allowed_cnt++;
        else blocked_cnt++;
      end
    endcase
    v.allowed = allowed_cnt;
    v.blocked = blocked_cnt;
    expected_verdicts.insert(expected_verdicts.size(), v);
  endtask

  task automatic check_beat();
    verdict_t want;
    if (expected_verdicts.size() == 0) begin
      report_mismatch("beat with nothing pending, decision", m_tdata_i[2:0], '0);
    end else begin
      want = expected_verdicts.pop_front();
      if (m_tdata_i[2:0] !== want.decision)
        report_mismatch("decision", m_tdata_i[2:0], want.decision);
      if (m_tdata_i[3] !== want.stored)
        report_mismatch("rule_stored", m_tdata_i[3], want.stored);
      if (m_tdata_i[35:4] !== want.allowed)
        report_mismatch("allowed_total", m_tdata_i[35:4], want.allowed);
      if (m_tdata_i[67:36] !== want.blocked)
        report_mismatch("blocked_total", m_tdata_i[67:36], want.blocked);
      if (m_tdata_i[71:68] !== 4'd0)
        report_mismatch("tdata padding", m_tdata_i[71:68], '0);
      compared_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_on   = 1'b1;
      allow_used  = 0;
      deny_used   = 0;
      allowed_cnt = '0;
      blocked_cnt = '0;
      expected_verdicts.delete();
      pending_o   = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) filter_on = cfg_data_i;
      // a result can never leave on the edge its own beat enters
      if (m_tvalid_i && m_tready_i) check_beat();
      if (s_tvalid_i && s_tready_i) predict_beat();
      pending_o = expected_verdicts.size();
    end
  end

endmodule

[sim/ipv4_prefix_policy_classifier_tb.sv]
`timescale 1ns / 1ps
// Stimulus top for the IPv4 prefix policy classifier regression: drives cfg and s_axis,
// throttles m_axis and reports the verdict. Depends on ippc_pkg and ippc_decision_checker.
module ipv4_prefix_policy_classifier_tb;
  import ippc_pkg::*;

  localparam int unsigned ALLOW_ENTRIES = 8;
  localparam int unsigned DENY_ENTRIES  = 8;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned RANDOM_PHASES = 10;
  localparam int unsigned PHASE_ITEMS   = 110;
  localparam int unsigned SPAN_PROBES   = 60;

  // unused mode code, decoded by the block as a check
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  typedef enum int {RX_STEADY, RX_COIN, RX_SPARSE, RX_PATTERN} rx_style_e;

  localparam logic [7:0] HEAD_OCTETS [12] = '{
    8'd0, 8'd10, 8'd100, 8'd127, 8'd169, 8'd172, 8'd192, 8'd198, 8'd203, 8'd224,
    8'd240, 8'd255};
  localparam logic [7:0] MID_OCTETS [12] = '{
    8'd0, 8'd15, 8'd16, 8'd31, 8'd32, 8'd51, 8'd64, 8'd127, 8'd128, 8'd168, 8'd254,
    8'd255};
  localparam logic [7:0] LOW_OCTETS [6] = '{8'd0, 8'd1, 8'd2, 8'd100, 8'd113, 8'd255};

  // boundary probes of the fixed ranges, empty tables
  localparam logic [ADDR_W-1:0] EDGE_PROBES [18] = '{
    32'h00000000, 32'hFFFFFFFF, 32'h0A000000, 32'hAC1FFFFF, 32'hAC200000,
    32'hC0A8FFFF, 32'h7FFFFFFF, 32'hA9FE0000, 32'h64400000, 32'h64800000,
    32'hC00000FF, 32'hC0000201, 32'hC63364C8, 32'hCB007100, 32'hE0000000,
    32'hF0000000, 32'hFFFFFFFE, 32'h08080808};

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_valid_i   = 1'b0;
  logic                   cfg_data_i    = 1'b0;
  logic                   cfg_ready_o;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [MODE_W-1:0]      s_axis_tuser  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  int mismatches;
  int pending;
  int compared;
  int refused;
  int cycles;
  int hold_req;
  int burst_left;
  bit sender_idles;
  int checks_sent;
  int allow_sent;
  int deny_sent;
  int cfg_writes;
  logic [ADDR_W-1:0] rule_nets [$];

  ipv4_prefix_policy_classifier #(
    .ALLOW_ENTRIES (ALLOW_ENTRIES),
    .DENY_ENTRIES  (DENY_ENTRIES)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  ippc_decision_checker #(
    .ALLOW_ENTRIES (ALLOW_ENTRIES),
    .DENY_ENTRIES  (DENY_ENTRIES)
  ) checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tuser_i    (s_axis_tuser),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .compared_o   (compared),
    .refused_o    (refused)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending", cycles, pending);
      $display("ipv4_prefix_policy_classifier regression: fail");
      $finish;
    end
  end

  // m_axis backpressure: random styles, plus a long hold whenever one is requested
  initial begin : result_sink
    rx_style_e style;
    int        style_left;
    int        tick;
    int        hold_seen;
    int        hold_left;
    style      = RX_STEADY;
    style_left = 0;
    tick       = 0;
    hold_seen  = 0;
    hold_left  = 0;
    forever begin
      @(negedge clk_i);
      if (hold_left == 0 && hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready = 1'b0;
      end else begin
        if (style_left == 0) begin
          style      = rx_style_e'($urandom_range(0, 3));
          style_left = $urandom_range(20, 200);
        end
        style_left--;
        tick++;
        case (style)
          RX_STEADY: m_axis_tready = 1'b1;
          RX_COIN:   m_axis_tready = 1'($urandom_range(0, 1));
          RX_SPARSE: m_axis_tready = ($urandom_range(0, 3) == 0);
          default:   m_axis_tready = (tick % 7) < 4;
        endcase
      end
    end
  end

  // Mostly addresses near the fixed ranges or near stored rules, some fully random.
  function automatic logic [ADDR_W-1:0] pick_address();
    int   sel;
    logic [7:0] o2;
    logic [7:0] o3;
    sel = $urandom_range(0, 19);
    if (sel < 9) begin
      o2 = ($urandom_range(0, 3) != 0) ? MID_OCTETS[$urandom_range(0, 11)] : 8'($urandom);
      o3 = ($urandom_range(0, 1) != 0) ? LOW_OCTETS[$urandom_range(0, 5)] : 8'($urandom);
      return {HEAD_OCTETS[$urandom_range(0, 11)], o2, o3, 8'($urandom)};
    end else if (sel < 15 && rule_nets.size() > 0) begin
      return rule_nets[$urandom_range(0, rule_nets.size() - 1)] ^
             ($urandom & (32'hFFFFFFFF >> $urandom_range(4, 32)));
    end else if (sel == 19) begin
      return 32'hFFFFFFFF;
    end
    return $urandom;
  endfunction

  task automatic idle_for(input int n);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  task automatic send_item(input logic [MODE_W-1:0] mode, input logic [ADDR_W-1:0] addr,
                           input logic [PLEN_W-1:0] len);
    if (burst_left == 0) begin
      if (sender_idles) idle_for($urandom_range(1, 8));
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = mode;
    s_axis_tdata  = {2'b00, len, addr};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (mode == MODE_ADD_ALLOW) begin
      allow_sent++;
      if (allow_sent <= ALLOW_ENTRIES) rule_nets.insert(rule_nets.size(), addr);
    end else if (mode == MODE_ADD_DENY) begin
      deny_sent++;
      if (deny_sent <= DENY_ENTRIES) rule_nets.insert(rule_nets.size(), addr);
    end else begin
      checks_sent++;
    end
  endtask

  // Stop offering and wait until every pending result has left, plus a short margin.
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    burst_left    = 0;
    while (pending != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_filter(input logic enable);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = enable;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    cfg_writes++;
  endtask

  task automatic send_random_item();
    int                r;
    logic [MODE_W-1:0] mode;
    r = $urandom_range(0, 99);
    if (r < 4 || (r < 7 && deny_sent >= DENY_ENTRIES - 1)) mode = MODE_ADD_ALLOW;
    else if (r < 7) mode = MODE_ADD_DENY;
    else if (r < 10) mode = MODE_SPARE;
    else mode = MODE_CHECK;
    if (mode == MODE_ADD_ALLOW || mode == MODE_ADD_DENY) begin
      send_item(mode, ($urandom_range(0, 1) != 0) ? $urandom : pick_address(),
                PLEN_W'($urandom_range(8, 40)));
    end else begin
      send_item(mode, pick_address(), PLEN_W'($urandom_range(0, 63)));
    end
  endtask

  initial begin : stimulus
    sender_idles = 1'b1;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // fixed ranges and their edges, reset filter setting
    foreach (EDGE_PROBES[i]) send_item(MODE_CHECK, EDGE_PROBES[i], 6'd0);
    send_item(MODE_SPARE, 32'hA9FEA9FE, 6'd63);
    // allow beats deny; prefix length above 32 saturates
    send_item(MODE_ADD_DENY, 32'h08080000, 6'd16);
    send_item(MODE_ADD_ALLOW, 32'h08080808, 6'd63);
    send_item(MODE_CHECK, 32'h08080808, 6'd0);
    send_item(MODE_CHECK, 32'h08080404, 6'd0);
    // host bits of the rule network are don't-care
    send_item(MODE_ADD_ALLOW, 32'h0A01FFFF, 6'd16);
    send_item(MODE_CHECK, 32'h0A010000, 6'd0);
    send_item(MODE_CHECK, 32'h0A020000, 6'd0);

    // filter off: everything allowed, inserts still land
    drain();
    write_filter(1'b0);
    send_item(MODE_CHECK, 32'h7F000001, 6'd0);
    send_item(MODE_CHECK, 32'h08080404, 6'd0);
    send_item(MODE_ADD_DENY, 32'h01020304, 6'd32);
    drain();
    write_filter(1'b1);
    send_item(MODE_CHECK, 32'h01020304, 6'd0);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain();
      if (p == 1) write_filter(1'b0);
      else if (p == 2) write_filter(1'b1);
      else write_filter($urandom_range(0, 3) != 0);
      sender_idles = (p % 3) != 2;
      if (p == 3) begin
        // sink stalls long while the source keeps pushing
        sender_idles = 1'b0;
        hold_req++;
      end
      repeat (PHASE_ITEMS) send_random_item();
    end

    // catch-all deny rule in the last slot, then both tables overflow
    drain();
    write_filter(1'b1);
    while (deny_sent < DENY_ENTRIES - 1) send_item(MODE_ADD_DENY, $urandom, 6'd32);
    send_item(MODE_ADD_DENY, 32'hDEADBEEF, 6'd0);
    repeat (SPAN_PROBES) send_item(MODE_CHECK, pick_address(), 6'd0);
    send_item(MODE_ADD_DENY, $urandom, 6'd24);
    while (allow_sent <= ALLOW_ENTRIES) send_item(MODE_ADD_ALLOW, $urandom, 6'd32);
    send_item(MODE_CHECK, $urandom, 6'd0);
    drain();

    $display("covered %0d checks, %0d allow and %0d deny inserts (%0d refused)",
             checks_sent, allow_sent, deny_sent, refused);
    $display("%0d filter writes, %0d result beats compared in %0d cycles",
             cfg_writes, compared, cycles);
    if (mismatches == 0 && pending == 0) begin
      $display("ipv4_prefix_policy_classifier regression: pass");
    end else begin
      $display("ipv4_prefix_policy_classifier regression: fail");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/ippc_pkg.sv
hw/rtl/ippc_rule_table.sv
hw/rtl/ippc_front.sv
hw/rtl/ippc_queue.sv
hw/rtl/ippc_back.sv
hw/rtl/ipv4_prefix_policy_classifier.sv
sim/ippc_decision_checker.sv
sim/ipv4_prefix_policy_classifier_tb.sv
